// ===== hw/rtl/pfnc_pkg.sv =====
// Package for the paired frame noise floor clamp.
// Holds the value width, the item and pair types, and the register map.
// No dependencies.
package pfnc_pkg;

  // Q11.8 level width and derived limits
  localparam int VALUE_WIDTH = 20;
  localparam int MARGIN_WIDTH = VALUE_WIDTH - 1;
  localparam int DEFAULT_MAX_BINS = 32;

  // APB register map
  localparam int ADDR_WIDTH = 3;
  localparam int DATA_WIDTH = 32;
  localparam logic REG_NOISE_MARGIN = 1'b0;

  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] ref_value;
    logic signed [VALUE_WIDTH-1:0] deg_value;
    logic                          last_bin;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] ref_out;
    logic signed [VALUE_WIDTH-1:0] deg_out;
    logic                          last_out;
  } out_item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] ref_level;
    logic signed [VALUE_WIDTH-1:0] deg_level;
  } pair_t;

  // Larger of two signed levels
  function automatic logic signed [VALUE_WIDTH-1:0] larger(
    input logic signed [VALUE_WIDTH-1:0] a,
    input logic signed [VALUE_WIDTH-1:0] b
  );
    larger = (a > b) ? a : b;
  endfunction

endpackage

// ===== hw/rtl/pfnc_cell.sv =====
// One cell of the pair chain: holds a stored bin pair.
// Takes its neighbor's pair on a shift. Depends on pfnc_pkg.
module pfnc_cell
  import pfnc_pkg::*;
(
  input  logic  clk,
  input  logic  shift,
  input  pair_t pair_in,
  output pair_t pair_q
);

  // Advance the chain by one place
  always_ff @(posedge clk) begin
    if (shift) begin
      pair_q <= pair_in;
    end
  end

endmodule

// ===== hw/rtl/paired_frame_noise_floor_clamp.sv =====
// Bins are taken one per cycle while loading. After the last bin the floor is computed,
// the pair chain is shifted up until the oldest pair of the frame reaches the top, and
// then one result per cycle is emitted while the output is not stalled. No bin of a new
// frame is taken until the last result of the current frame has been emitted.
// Reset: rst clears control, count, peak, margin and the output valid; the chain
// holds no reset and only pairs of the current frame are read.
module paired_frame_noise_floor_clamp
  import pfnc_pkg::*;
#(
  parameter int MAX_BINS = DEFAULT_MAX_BINS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output logic [DATA_WIDTH-1:0] prdata,
  output logic                  pready
);

  localparam int CntWidth = $clog2(MAX_BINS + 1);
  localparam logic [CntWidth-1:0] CntMax = CntWidth'(MAX_BINS);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_FLOOR = 2'd1;
  localparam logic [1:0] ST_ALIGN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]                    state, state_next;
  logic [CntWidth-1:0]           bin_count, bin_count_next;
  logic [CntWidth-1:0]           step_count, step_count_next;
  logic signed [VALUE_WIDTH-1:0] frame_peak, frame_peak_next;
  logic signed [VALUE_WIDTH-1:0] floor_level;
  logic [MARGIN_WIDTH-1:0]       noise_margin;
  logic signed [VALUE_WIDTH:0]   floor_diff;
  logic                          in_fire, store_ok, emit_fire, shift;
  pair_t                         chain [MAX_BINS];
  pair_t                         pair_new;

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_margin <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_NOISE_MARGIN) begin
      noise_margin <= pwdata[MARGIN_WIDTH-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_NOISE_MARGIN) begin
      prdata[MARGIN_WIDTH-1:0] = noise_margin;
    end
  end

  // Handshake qualifiers
  assign in_ready  = (state == ST_LOAD);
  assign in_fire   = in_valid && in_ready;
  assign store_ok  = in_fire && (bin_count != CntMax);
  assign emit_fire = (state == ST_EMIT) && (!out_valid || out_ready);
  assign shift     = store_ok || ((state == ST_ALIGN) && step_count != '0) || emit_fire;

  assign pair_new.ref_level = in_data.ref_value;
  assign pair_new.deg_level = in_data.deg_value;

  // Row of cells: new pair enters at the bottom, oldest leaves at the top
  for (genvar i = 0; i < MAX_BINS; i++) begin : g_cell
    if (i == 0) begin : g_head
      pfnc_cell u_cell (.clk(clk), .shift(shift), .pair_in(pair_new), .pair_q(chain[i]));
    end else begin : g_body
      pfnc_cell u_cell (.clk(clk), .shift(shift), .pair_in(chain[i-1]), .pair_q(chain[i]));
    end
  end

  // Floor: peak minus margin, saturate at the most negative level
  assign floor_diff = {frame_peak[VALUE_WIDTH-1], frame_peak}
                    - {2'b00, noise_margin};

  // Sequencer: load, compute floor, align oldest pair to the top, emit
  always_comb begin
    state_next      = state;
    bin_count_next  = bin_count;
    step_count_next = step_count;
    frame_peak_next = frame_peak;
    unique case (state)
      ST_LOAD: begin
        if (store_ok) begin
          bin_count_next  = bin_count + 1'b1;
          frame_peak_next = larger(frame_peak,
                                   larger(in_data.ref_value, in_data.deg_value));
        end
        if (in_fire && in_data.last_bin) begin
          state_next = ST_FLOOR;
        end
      end
      ST_FLOOR: begin
        step_count_next = CntMax - bin_count;
        state_next      = ST_ALIGN;
      end
      ST_ALIGN: begin
        if (step_count != '0) begin
          step_count_next = step_count - 1'b1;
        end else begin
          step_count_next = bin_count;
          state_next      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          step_count_next = step_count - 1'b1;
          if (step_count == CntWidth'(1)) begin
            bin_count_next  = '0;
            frame_peak_next = VAL_MIN;
            state_next      = ST_LOAD;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      bin_count  <= '0;
      step_count <= '0;
      frame_peak <= VAL_MIN;
    end else begin
      state      <= state_next;
      bin_count  <= bin_count_next;
      step_count <= step_count_next;
      frame_peak <= frame_peak_next;
    end
  end

  // Hold the floor for the readout
  always_ff @(posedge clk) begin
    if (state == ST_FLOOR) begin
      floor_level <= (floor_diff[VALUE_WIDTH] != floor_diff[VALUE_WIDTH-1])
                   ? VAL_MIN : floor_diff[VALUE_WIDTH-1:0];
    end
  end

  // Output register: clamp the top pair
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data.ref_out  <= larger(floor_level, chain[MAX_BINS-1].ref_level);
      out_data.deg_out  <= larger(floor_level, chain[MAX_BINS-1].deg_level);
      out_data.last_out <= (step_count == CntWidth'(1));
    end
  end

endmodule

// ===== hw/rtl/pfnc_checker.sv =====
// Port checker for the paired frame noise floor clamp, bound to the top level.
// Depends on pfnc_pkg and paired_frame_noise_floor_clamp.
module pfnc_checker
  import pfnc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // Output valid is clear right after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The last bin of a frame stops intake for the readout
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.last_bin |=> !in_ready)
    else $error("input taken right after last bin");

  // No intake while a frame is still being emitted
  a_emit_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last_out |-> !in_ready)
    else $error("input ready during readout");

endmodule

bind paired_frame_noise_floor_clamp pfnc_checker u_pfnc_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
